>>> src/dbmc_pkg.sv
// ----------------------------------------------------------------------------
// Debounced media controls package
// Shared constants, register indexes and button numbering for the core.
// ----------------------------------------------------------------------------
package dbmc_pkg;

  localparam int unsigned BTN_COUNT = 4;

  // Button slots, in the order they are handled within one tick.
  localparam int unsigned BTN_PLAY     = 0;
  localparam int unsigned BTN_OSD      = 1;
  localparam int unsigned BTN_VOL_UP   = 2;
  localparam int unsigned BTN_VOL_DOWN = 3;

  localparam int unsigned CFG_WIDTH   = 16;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned STAMP_WIDTH = 32;
  localparam int unsigned STEP_WIDTH  = 4;
  localparam int unsigned MASK_WIDTH  = 3;
  localparam int unsigned LEVEL_WIDTH = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE_PLAY   = 2'd0,
    REG_DEBOUNCE_OSD    = 2'd1,
    REG_DEBOUNCE_VOLUME = 2'd2,
    REG_VOLUME_SHOW     = 2'd3
  } reg_index_t;

  localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET    = 16'd30;
  localparam logic [CFG_WIDTH-1:0] VOLUME_SHOW_RESET = 16'd1500;

  localparam int unsigned           VOL_STEPS      = 16;
  localparam logic [STEP_WIDTH-1:0] VOL_TOP_STEP   = STEP_WIDTH'(VOL_STEPS - 1);
  localparam logic [STEP_WIDTH-1:0] VOL_RESET_STEP = 4'd8;

  localparam logic [MASK_WIDTH-1:0]  MASK_ALL   = 3'h7;
  localparam logic [LEVEL_WIDTH-1:0] LEVEL_MULT = 9'd17;
  localparam logic [LEVEL_WIDTH-1:0] LEVEL_CAP  = 9'd256;

endpackage

>>> src/debounced_button_media_controls_core.sv
// ----------------------------------------------------------------------------
// Debounced button media controls core
// Debounces four active-low buttons against a millisecond timestamp and
// keeps pause, overlay mask and volume step state with a timed indicator.
// ----------------------------------------------------------------------------
// Each request is one poll tick and produces exactly one result. A request is
// taken whenever in_ready is high: button debouncing and the shared state
// update happen in the cycle in which the request is accepted, and the result
// is written into the output register at that same edge, so it is offered in
// the cycle after acceptance. That output register is the only stage, so
// in_ready is high whenever it is empty or being drained in the same cycle; the
// sustained rate is one tick per clock while out_ready is high. Configuration
// writes take effect at once and should only be made while no result is pending.
module debounced_button_media_controls_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [dbmc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dbmc_pkg::CFG_WIDTH-1:0]    cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [dbmc_pkg::STAMP_WIDTH-1:0]  now_ms,
  input  logic                              raw_play,
  input  logic                              raw_osd,
  input  logic                              raw_vol_up,
  input  logic                              raw_vol_down,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              paused_flag,
  output logic [dbmc_pkg::MASK_WIDTH-1:0]   overlay_mask,
  output logic [dbmc_pkg::STEP_WIDTH-1:0]   volume_step_out,
  output logic [dbmc_pkg::LEVEL_WIDTH-1:0]  volume_level,
  output logic                              volume_visible
);

  localparam int unsigned NB = dbmc_pkg::BTN_COUNT;
  localparam int unsigned SW = dbmc_pkg::STAMP_WIDTH;

  logic [dbmc_pkg::CFG_WIDTH-1:0] debounce_play_ms;
  logic [dbmc_pkg::CFG_WIDTH-1:0] debounce_osd_ms;
  logic [dbmc_pkg::CFG_WIDTH-1:0] debounce_volume_ms;
  logic [dbmc_pkg::CFG_WIDTH-1:0] volume_show_ms;

  logic [NB-1:0]  last_level;
  logic [NB-1:0]  stable_level;
  logic [SW-1:0]  change_stamp [NB];
  logic           pause_state;
  logic [dbmc_pkg::MASK_WIDTH-1:0] mask_state;
  logic [dbmc_pkg::STEP_WIDTH-1:0] step_state;
  logic           show_state;
  logic [SW-1:0]  show_deadline;

  logic           accept;
  logic [NB-1:0]  raw;
  logic [NB-1:0]  stable_level_next;
  logic [NB-1:0]  press;
  logic [SW-1:0]  stamp_eff [NB];
  logic [dbmc_pkg::CFG_WIDTH-1:0] hold [NB];
  logic           pause_next;
  logic [dbmc_pkg::MASK_WIDTH-1:0] mask_next;
  logic [dbmc_pkg::STEP_WIDTH-1:0] step_up;
  logic [dbmc_pkg::STEP_WIDTH-1:0] step_next;
  logic           vol_press;
  logic           show_raised;
  logic [SW-1:0]  deadline_next;
  logic           show_next;
  logic [dbmc_pkg::LEVEL_WIDTH-1:0] level_prod;
  logic [dbmc_pkg::LEVEL_WIDTH-1:0] level_next;

  function automatic logic [dbmc_pkg::LEVEL_WIDTH-1:0] LEVEL_WIDTH_MUL(
    input logic [dbmc_pkg::STEP_WIDTH-1:0] step
  );
    logic [dbmc_pkg::LEVEL_WIDTH-1:0] wide;
    wide = dbmc_pkg::LEVEL_WIDTH'(step);
    return (wide << 4) + wide;
  endfunction

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign raw      = {raw_vol_down, raw_vol_up, raw_osd, raw_play};

  assign hold[dbmc_pkg::BTN_PLAY]     = debounce_play_ms;
  assign hold[dbmc_pkg::BTN_OSD]      = debounce_osd_ms;
  assign hold[dbmc_pkg::BTN_VOL_UP]   = debounce_volume_ms;
  assign hold[dbmc_pkg::BTN_VOL_DOWN] = debounce_volume_ms;

  // A change restarts the stable window at this tick's timestamp, so it is
  // confirmed in the same tick only when the debounce time is zero.
  always_comb begin
    for (int b = 0; b < NB; b++) begin
      stamp_eff[b] = (raw[b] != last_level[b]) ? now_ms : change_stamp[b];
      if ((SW'(now_ms - stamp_eff[b]) >= SW'(hold[b])) && (raw[b] != stable_level[b])) begin
        stable_level_next[b] = raw[b];
        press[b]             = stable_level[b] && !raw[b];
      end else begin
        stable_level_next[b] = stable_level[b];
        press[b]             = 1'b0;
      end
    end
  end

  always_comb begin
    pause_next = pause_state ^ press[dbmc_pkg::BTN_PLAY];
    mask_next  = press[dbmc_pkg::BTN_OSD] ? (mask_state - 3'd1) : mask_state;

    // Volume up acts before volume down when both land in one tick.
    step_up = step_state;
    if (press[dbmc_pkg::BTN_VOL_UP] && (step_state < dbmc_pkg::VOL_TOP_STEP)) begin
      step_up = step_state + 4'd1;
    end
    step_next = step_up;
    if (press[dbmc_pkg::BTN_VOL_DOWN] && (step_up != '0)) begin
      step_next = step_up - 4'd1;
    end

    vol_press     = press[dbmc_pkg::BTN_VOL_UP] || press[dbmc_pkg::BTN_VOL_DOWN];
    deadline_next = vol_press ? (now_ms + SW'(volume_show_ms)) : show_deadline;
    show_raised   = show_state || vol_press;
    show_next     = show_raised && !(now_ms >= deadline_next);

    level_prod = LEVEL_WIDTH_MUL(step_next);
    if (step_next == '0) begin
      level_next = '0;
    end else if (level_prod > dbmc_pkg::LEVEL_CAP) begin
      level_next = dbmc_pkg::LEVEL_CAP;
    end else begin
      level_next = level_prod;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_play_ms   <= dbmc_pkg::DEBOUNCE_RESET;
      debounce_osd_ms    <= dbmc_pkg::DEBOUNCE_RESET;
      debounce_volume_ms <= dbmc_pkg::DEBOUNCE_RESET;
      volume_show_ms     <= dbmc_pkg::VOLUME_SHOW_RESET;
    end else if (cfg_we) begin
      case (dbmc_pkg::reg_index_t'(cfg_index))
        dbmc_pkg::REG_DEBOUNCE_PLAY:   debounce_play_ms   <= cfg_wdata;
        dbmc_pkg::REG_DEBOUNCE_OSD:    debounce_osd_ms    <= cfg_wdata;
        dbmc_pkg::REG_DEBOUNCE_VOLUME: debounce_volume_ms <= cfg_wdata;
        dbmc_pkg::REG_VOLUME_SHOW:     volume_show_ms     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_level    <= '1;
      stable_level  <= '1;
      for (int b = 0; b < NB; b++) begin
        change_stamp[b] <= '0;
      end
      pause_state   <= 1'b0;
      mask_state    <= dbmc_pkg::MASK_ALL;
      step_state    <= dbmc_pkg::VOL_RESET_STEP;
      show_state    <= 1'b0;
      show_deadline <= '0;
    end else if (accept) begin
      last_level    <= raw;
      stable_level  <= stable_level_next;
      for (int b = 0; b < NB; b++) begin
        change_stamp[b] <= stamp_eff[b];
      end
      pause_state   <= pause_next;
      mask_state    <= mask_next;
      step_state    <= step_next;
      show_state    <= show_next;
      show_deadline <= deadline_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      paused_flag     <= pause_next;
      overlay_mask    <= mask_next;
      volume_step_out <= step_next;
      volume_level    <= level_next;
      volume_visible  <= show_next;
    end
  end

  // An accepted request always leaves a result behind it.
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted request produced no result");

  // Shared state moves only on an accepted request.
  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !accept |=> ($stable(step_state) && $stable(mask_state) && $stable(pause_state)))
    else $error("media state changed without a request");

  // The level is zero exactly when the step is zero.
  a_level_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((volume_level == '0) == (volume_step_out == '0)))
    else $error("volume level disagrees with step");

endmodule
